[hdl/tcw_pkg.sv]
package tcw_pkg;

  // Screen geometry.
  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int NUM_CELLS   = SCREEN_ROWS * SCREEN_COLS;
  // Cells that move during a scroll: every row but the top one.
  localparam int MOVE_CELLS  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(NUM_CELLS);

  // Field widths of the request and the result.
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int TROW_W = 6;
  localparam int TCOL_W = 7;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;

  // Width of row * SCREEN_COLS + column for any request coordinates.
  localparam int LIN_W = $clog2(((1 << TROW_W) - 1) * SCREEN_COLS + (1 << TCOL_W));

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_WRITE  = 6'b000100,
    S_SCROLL = 6'b001000,
    S_BLANK  = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  // Access to the screen store: one write and one read per cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } resp_t;

endpackage

[hdl/tcw_screen_ram.sv]
module tcw_screen_ram import tcw_pkg::*; (
  input  logic              clk_i,
  input  ram_req_t          ram_req_i,
  output logic [CELL_W-1:0] rd_data_o
);

  logic [CELL_W-1:0] mem_q [NUM_CELLS];
  logic [CELL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem_q[ram_req_i.waddr] <= ram_req_i.wdata;
    end
  end

  // Read data is held until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (ram_req_i.re) begin
      rd_data_q <= mem_q[ram_req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tcw_addr_unit.sv]
module tcw_addr_unit import tcw_pkg::*; (
  input  logic [TROW_W-1:0] row_i,
  input  logic [TCOL_W-1:0] col_i,
  output logic [LIN_W-1:0]  lin_o
);

  // Linear cell index: row times the screen width plus the column.
  assign lin_o = LIN_W'(row_i) * LIN_W'(SCREEN_COLS) + LIN_W'(col_i);

endmodule

[hdl/tcw_seq.sv]
module tcw_seq import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [TROW_W-1:0] target_row_i,
  input  logic [TCOL_W-1:0] target_col_i,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic [CELL_W-1:0] rd_data_i,
  output ram_req_t          ram_req_o,
  input  logic              resp_ready_i,
  output resp_t             resp_o
);

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [TROW_W-1:0] trow_q, trow_d;
  logic [TCOL_W-1:0] tcol_q, tcol_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              scrolled_q, scrolled_d;
  logic              pend_q, pend_d;

  logic [TROW_W-1:0] au_row;
  logic [TCOL_W-1:0] au_col;
  logic [LIN_W-1:0]  au_lin;
  logic [CELL_W-1:0] blank;
  logic              is_nl;
  logic              is_bs;
  logic              last_row;
  logic              in_range;

  tcw_addr_unit u_addr (
    .row_i (au_row),
    .col_i (au_col),
    .lin_o (au_lin)
  );

  assign blank    = {attr_i, CH_SPACE};
  assign is_nl    = (char_q == CH_LF) || (char_q == CH_CR);
  assign is_bs    = (char_q == CH_BS);
  assign last_row = (int'(row_q) == SCREEN_ROWS - 1);
  assign in_range = (int'(trow_q) < SCREEN_ROWS) && (int'(tcol_q) < SCREEN_COLS);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    char_d     = char_q;
    trow_d     = trow_q;
    tcol_d     = tcol_q;
    row_d      = row_q;
    col_d      = col_q;
    idx_d      = idx_q;
    scrolled_d = scrolled_q;
    pend_d     = pend_q;
    au_row     = TROW_W'(row_q);
    au_col     = TCOL_W'(col_q);
    ram_req_o  = '0;
    resp_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d      = req_e'(req_type_i);
          char_d     = char_code_i;
          trow_d     = target_row_i;
          tcol_d     = target_col_i;
          scrolled_d = 1'b0;
          pend_d     = 1'b0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_q)
          REQ_PUT: begin
            if (is_nl) begin
              col_d = '0;
              if (last_row) begin
                scrolled_d = 1'b1;
                idx_d      = '0;
                state_d    = S_SCROLL;
              end else begin
                row_d   = row_q + 1'b1;
                state_d = S_RESP;
              end
            end else if (is_bs) begin
              if (col_q != '0) begin
                col_d   = col_q - 1'b1;
                state_d = S_WRITE;
              end else if (row_q != '0) begin
                row_d   = row_q - 1'b1;
                col_d   = COL_W'(SCREEN_COLS - 1);
                state_d = S_WRITE;
              end else begin
                state_d = S_RESP;
              end
            end else if (int'(col_q) >= SCREEN_COLS) begin
              col_d = '0;
              if (last_row) begin
                scrolled_d = 1'b1;
                pend_d     = 1'b1;
                idx_d      = '0;
                state_d    = S_SCROLL;
              end else begin
                row_d   = row_q + 1'b1;
                state_d = S_WRITE;
              end
            end else begin
              state_d = S_WRITE;
            end
          end
          REQ_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            idx_d   = '0;
            state_d = S_BLANK;
          end
          REQ_SET: begin
            row_d   = (int'(trow_q) >= SCREEN_ROWS) ? ROW_W'(SCREEN_ROWS - 1)
                                                    : ROW_W'(trow_q);
            col_d   = (int'(tcol_q) >= SCREEN_COLS) ? COL_W'(SCREEN_COLS - 1)
                                                    : COL_W'(tcol_q);
            state_d = S_RESP;
          end
          REQ_READ: begin
            au_row          = trow_q;
            au_col          = tcol_q;
            ram_req_o.re    = in_range;
            ram_req_o.raddr = au_lin[ADDR_W-1:0];
            state_d         = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end

      S_WRITE: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = au_lin[ADDR_W-1:0];
        ram_req_o.wdata = is_bs ? blank : {attr_i, char_q};
        if (!is_bs) begin
          col_d = col_q + 1'b1;
        end
        state_d = S_RESP;
      end

      // Copy each cell from one row below; each write lands in the cycle after its read.
      S_SCROLL: begin
        if (idx_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = idx_q - 1'b1;
          ram_req_o.wdata = rd_data_i;
        end
        if (idx_q != ADDR_W'(MOVE_CELLS)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q + ADDR_W'(SCREEN_COLS);
          idx_d           = idx_q + 1'b1;
        end else begin
          state_d = S_BLANK;
        end
      end

      // Blank from idx to the end of the store: bottom row or whole screen.
      S_BLANK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = blank;
        if (idx_q == ADDR_W'(NUM_CELLS - 1)) begin
          state_d = pend_q ? S_WRITE : S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RESP: begin
        resp_o.valid     = 1'b1;
        resp_o.row       = row_q;
        resp_o.col       = col_q;
        resp_o.offset    = au_lin[OFF_W-1:0];
        resp_o.cell_data = ((req_q == REQ_READ) && in_range) ? rd_data_i : '0;
        resp_o.scrolled  = scrolled_q;
        if (resp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      idx_q      <= '0;
      scrolled_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      idx_q      <= idx_d;
      scrolled_q <= scrolled_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    char_q <= char_d;
    trow_q <= trow_d;
    tcol_q <= tcol_d;
  end

endmodule

[hdl/text_console_writer.sv]
// Text-mode console engine: a 25 x 80 store of 16-bit cells (character in the
// low byte, attribute in the high byte) and a cursor.
// Requests arrive on the input channel (in_valid_i / in_stall_o) and each one
// gives exactly one result on the output channel (out_valid_o / out_stall_i).
// A transfer takes place on a rising edge with valid high and stall low.
// The attribute register is written whenever text_attribute_we_i is high; it
// must only be changed while no request is in flight.
// Set cursor, read cell, a newline without scroll and a backspace at the home
// position go straight from execution to the result; a printable character
// or a backspace first writes its cell. A scroll first moves 24 rows through
// the single store port pair, then blanks the bottom row; a clear blanks the
// whole store, one cell written per cycle.
// One request is worked on at a time: the next input transfer is taken the
// cycle after the result has been loaded into the output register.
// A stalled result waits in the output register; the sequencer then holds
// its own result until that register frees up.
// Reset puts the cursor at row 0, column 0 and the attribute to 0x0F; the
// screen store is not cleared, so software issues a clear before reading.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [TROW_W-1:0] target_row_i,
  input  logic [TCOL_W-1:0] target_col_i,
  input  logic              text_attribute_we_i,
  input  logic [ATTR_W-1:0] text_attribute_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [OFF_W-1:0]  cursor_offset_o,
  output logic [CELL_W-1:0] cell_value_o,
  output logic              scrolled_o
);

  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              out_valid_q, out_valid_d;
  resp_t             out_q;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] rd_data;
  resp_t             resp;
  logic              resp_ready;

  // The attribute byte used for every character and blank written.
  assign attr_d = text_attribute_we_i ? text_attribute_i : attr_q;

  // The output register can take a result when empty or being drained.
  assign resp_ready = !out_valid_q || !out_stall_i;

  tcw_screen_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rd_data_o (rd_data)
  );

  tcw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .attr_i       (attr_q),
    .rd_data_i    (rd_data),
    .ram_req_o    (ram_req),
    .resp_ready_i (resp_ready),
    .resp_o       (resp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (resp.valid && resp_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      attr_q      <= attr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; it only changes when a new result is loaded.
  always_ff @(posedge clk_i) begin
    if (resp.valid && resp_ready) begin
      out_q <= resp;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = out_q.row;
  assign cursor_col_o    = out_q.col;
  assign cursor_offset_o = out_q.offset;
  assign cell_value_o    = out_q.cell_data;
  assign scrolled_o      = out_q.scrolled;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_row_o) < SCREEN_ROWS) &&
                    (int'(cursor_col_o) <= SCREEN_COLS))
    else $error("cursor outside the screen");

  a_offset_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_offset_o) ==
                     int'(cursor_row_o) * SCREEN_COLS + int'(cursor_col_o)))
    else $error("cursor offset does not match row and column");

  a_scroll_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scrolled_o) |-> (int'(cursor_row_o) == SCREEN_ROWS - 1))
    else $error("scroll reported with cursor off the last row");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");
`endif

endmodule

[tb/text_console_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the console engine, keeps its own copy of the
// screen, the cursor and the attribute register, and compares every result
// transfer against the oldest expectation in order.
module text_console_checker import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [TROW_W-1:0] target_row_i,
  input  logic [TCOL_W-1:0] target_col_i,
  input  logic              text_attribute_we_i,
  input  logic [ATTR_W-1:0] text_attribute_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ROW_W-1:0]  cursor_row_i,
  input  logic [COL_W-1:0]  cursor_col_i,
  input  logic [OFF_W-1:0]  cursor_offset_i,
  input  logic [CELL_W-1:0] cell_value_i,
  input  logic              scrolled_i,
  output int                error_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                scroll_count_o
);

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_result_t;

  logic [CELL_W-1:0] screen_q [NUM_CELLS];
  int unsigned       row_q;
  int unsigned       col_q;
  logic [ATTR_W-1:0] attr_q;
  console_result_t   cursor_results_q [$];

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_q, CH_SPACE};
  endfunction

  // Start of the next row; at the bottom the screen moves up by one row.
  task automatic advance_row(output logic scrolled);
    scrolled = 1'b0;
    col_q = 0;
    row_q++;
    if (row_q >= SCREEN_ROWS) begin
      for (int i = 0; i < MOVE_CELLS; i++) screen_q[i] = screen_q[i + SCREEN_COLS];
      for (int i = MOVE_CELLS; i < NUM_CELLS; i++) screen_q[i] = blank_cell();
      row_q = SCREEN_ROWS - 1;
      scrolled = 1'b1;
    end
  endtask

  task automatic predict_console(input req_e kind, input logic [CHAR_W-1:0] ch,
                                 input logic [TROW_W-1:0] trow,
                                 input logic [TCOL_W-1:0] tcol,
                                 output console_result_t res);
    logic [CELL_W-1:0] read_val;
    logic              scrolled;
    read_val = '0;
    scrolled = 1'b0;
    case (kind)
      REQ_PUT: begin
        if (ch == CH_LF || ch == CH_CR) begin
          advance_row(scrolled);
        end else if (ch == CH_BS) begin
          if (col_q > 0) begin
            col_q--;
            screen_q[row_q * SCREEN_COLS + col_q] = blank_cell();
          end else if (row_q > 0) begin
            row_q--;
            col_q = SCREEN_COLS - 1;
            screen_q[row_q * SCREEN_COLS + col_q] = blank_cell();
          end
        end else begin
          if (col_q >= SCREEN_COLS) advance_row(scrolled);
          screen_q[row_q * SCREEN_COLS + col_q] = {attr_q, ch};
          col_q++;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NUM_CELLS; i++) screen_q[i] = blank_cell();
        row_q = 0;
        col_q = 0;
      end
      REQ_SET: begin
        row_q = (int'(trow) >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(trow);
        col_q = (int'(tcol) >= SCREEN_COLS) ? SCREEN_COLS - 1 : int'(tcol);
      end
      default: begin
        if (trow < SCREEN_ROWS && tcol < SCREEN_COLS) begin
          read_val = screen_q[trow * SCREEN_COLS + tcol];
        end
      end
    endcase
    res.row       = ROW_W'(row_q);
    res.col       = COL_W'(col_q);
    res.offset    = OFF_W'(row_q * SCREEN_COLS + col_q);
    res.cell_data = read_val;
    res.scrolled  = scrolled;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    console_result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CELLS; i++) screen_q[i] = '0;
      row_q = 0;
      col_q = 0;
      attr_q = ATTR_RESET;
      cursor_results_q.delete();
      error_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      scroll_count_o = 0;
    end else begin
      // A result leaving in the same cycle as a request arrives belongs to an
      // older request, so it is matched first.
      if (out_valid_i && !out_stall_i) begin
        if (cursor_results_q.size() == 0) begin
          $display("%0t: result transfer with no request outstanding", $time);
          error_count_o++;
        end else begin
          want = cursor_results_q.pop_front();
          checked_o++;
          compare_field("cursor_row", int'(want.row), int'(cursor_row_i));
          compare_field("cursor_col", int'(want.col), int'(cursor_col_i));
          compare_field("cursor_offset", int'(want.offset), int'(cursor_offset_i));
          compare_field("cell_value", int'(want.cell_data), int'(cell_value_i));
          compare_field("scrolled", int'(want.scrolled), int'(scrolled_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_console(req_e'(req_type_i), char_code_i, target_row_i, target_col_i, res);
        if (res.scrolled) scroll_count_o++;
        cursor_results_q.push_back(res);
      end
      if (text_attribute_we_i) attr_q = text_attribute_i;
      pending_o = cursor_results_q.size();
    end
  end

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the text console engine. The checker beside the
// block does all prediction and comparison; this module only drives requests,
// attribute writes and output stalls, and watches for a hung block.
module text_console_writer_tb;
  import tcw_pkg::*;

  // A clear or a scroll keeps the block busy while it walks the store cell by
  // cell, and both sides may stall heavily on top of that, so the limit allows
  // several times that span without any transfer.
  localparam int IDLE_LIMIT     = 20000;
  localparam int ITEMS_PER_PASS = 310;
  localparam int ATTR_INTERVAL  = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  req_type = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [TROW_W-1:0] target_row = '0;
  logic [TCOL_W-1:0] target_col = '0;
  logic              attr_we = 1'b0;
  logic [ATTR_W-1:0] attr_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [OFF_W-1:0]  cursor_offset;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  int error_count;
  int pending;
  int checked;
  int scroll_count;
  int send_idle_pct = 21;
  int recv_idle_pct = 80;
  int requests_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  text_console_writer dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .req_type_i          (req_type),
    .char_code_i         (char_code),
    .target_row_i        (target_row),
    .target_col_i        (target_col),
    .text_attribute_we_i (attr_we),
    .text_attribute_i    (attr_value),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .cursor_row_o        (cursor_row),
    .cursor_col_o        (cursor_col),
    .cursor_offset_o     (cursor_offset),
    .cell_value_o        (cell_value),
    .scrolled_o          (scrolled)
  );

  text_console_checker u_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .req_type_i          (req_type),
    .char_code_i         (char_code),
    .target_row_i        (target_row),
    .target_col_i        (target_col),
    .text_attribute_we_i (attr_we),
    .text_attribute_i    (attr_value),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .cursor_row_i        (cursor_row),
    .cursor_col_i        (cursor_col),
    .cursor_offset_i     (cursor_offset),
    .cell_value_i        (cell_value),
    .scrolled_i          (scrolled),
    .error_count_o       (error_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .scroll_count_o      (scroll_count)
  );

  // The receiving side decides afresh on every falling edge whether to hold
  // off the next result transfer. Nothing is stalled during reset.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Presents one request and returns at the falling edge after its transfer.
  // Called at a falling edge. The sender may first idle for a random number of
  // cycles; valid is only lowered for an idle cycle, so back-to-back requests
  // keep it high throughout.
  task automatic send_req(input req_e kind, input logic [CHAR_W-1:0] ch,
                          input logic [TROW_W-1:0] trow, input logic [TCOL_W-1:0] tcol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    char_code  <= ch;
    target_row <= trow;
    target_col <= tcol;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  // The fields that a request does not use are still filled with random bits.
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_req(REQ_PUT, ch, TROW_W'($urandom), TCOL_W'($urandom));
  endtask

  task automatic place_cursor(input logic [TROW_W-1:0] trow, input logic [TCOL_W-1:0] tcol);
    send_req(REQ_SET, CHAR_W'($urandom), trow, tcol);
  endtask

  task automatic read_cell(input logic [TROW_W-1:0] trow, input logic [TCOL_W-1:0] tcol);
    send_req(REQ_READ, CHAR_W'($urandom), trow, tcol);
  endtask

  // The sender stops and waits until every outstanding result has been
  // taken. Valid is lowered first, so the block is idle on return.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // The attribute register may only change while nothing is in flight.
  task automatic write_attr(input logic [ATTR_W-1:0] value);
    drain();
    attr_we    <= 1'b1;
    attr_value <= value;
    @(negedge clk);
    attr_we    <= 1'b0;
  endtask

  // Any character code other than the three control codes is printable.
  function automatic logic [CHAR_W-1:0] rand_glyph();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(255)); while (ch == CH_BS || ch == CH_LF || ch == CH_CR);
    return ch;
  endfunction

  // One random request, or a run of printable text. Runs of text are what
  // carry the cursor to the right margin, so they make up a good share of
  // the traffic; set cursor often lands on the bottom row, which makes the
  // line feeds that follow scroll the screen.
  task automatic send_random();
    int pick;
    int run_len;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_req(REQ_CLEAR, CHAR_W'($urandom), TROW_W'($urandom), TCOL_W'($urandom));
    end else if (pick < 10) begin
      put_char($urandom_range(1) ? CH_LF : CH_CR);
    end else if (pick < 20) begin
      put_char(CH_BS);
    end else if (pick < 35) begin
      if ($urandom_range(1)) begin
        place_cursor(TROW_W'($urandom_range(SCREEN_ROWS - 1)),
                     TCOL_W'($urandom_range(SCREEN_COLS - 1)));
      end else begin
        place_cursor(TROW_W'($urandom), TCOL_W'($urandom));
      end
    end else if (pick < 55) begin
      // The whole store has been written by the clear in the directed part,
      // so any read is legal; some fall outside the screen on purpose.
      if ($urandom_range(4) != 0) begin
        read_cell(TROW_W'($urandom_range(SCREEN_ROWS - 1)),
                  TCOL_W'($urandom_range(SCREEN_COLS - 1)));
      end else begin
        read_cell(TROW_W'($urandom), TCOL_W'($urandom));
      end
    end else begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) put_char(rand_glyph());
    end
  endtask

  initial begin
    int next_attr_at;
    int pass_end;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Reads inside the screen only come after the first clear,
    // since the store holds nothing defined until then.
    read_cell(6'd63, 7'd127);
    read_cell(TROW_W'(SCREEN_ROWS - 1), TCOL_W'(SCREEN_COLS));
    read_cell(TROW_W'(SCREEN_ROWS), 7'd0);
    put_char("A");                          // written with the reset attribute
    send_req(REQ_CLEAR, CHAR_W'($urandom), TROW_W'($urandom), TCOL_W'($urandom));
    read_cell(6'd0, 7'd0);
    put_char(CH_BS);                        // backspace at home does nothing

    write_attr(8'h00);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CH_BS);
    read_cell(6'd0, 7'd0);
    place_cursor(6'd63, 7'd127);            // both coordinates clamp

    write_attr(8'hFF);
    put_char("x");                          // column now equals the width
    put_char(CH_BS);                        // steps back from the width
    put_char("x");
    put_char("y");                          // wraps off the bottom row and scrolls
    read_cell(TROW_W'(SCREEN_ROWS - 2), TCOL_W'(SCREEN_COLS - 1));
    read_cell(TROW_W'(SCREEN_ROWS - 1), 7'd0);
    put_char(CH_CR);                        // line end on the bottom row scrolls
    place_cursor(6'd3, 7'd5);
    put_char(CH_LF);
    put_char(CH_BS);                        // back across the row boundary
    place_cursor(6'd0, TCOL_W'(SCREEN_COLS - 1));
    put_char("z");
    put_char("w");                          // wraps without a scroll

    // Random part in three passes with different idling on the two sides,
    // the last with none at all. The attribute is rewritten at the start of
    // each pass and every hundred requests or so, each time with the block
    // drained first.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_attr(pass == 2 ? ATTR_RESET : 8'($urandom_range(255)));
      pass_end = requests_sent + ITEMS_PER_PASS;
      next_attr_at = requests_sent + ATTR_INTERVAL;
      while (requests_sent < pass_end) begin
        send_random();
        if (requests_sent >= next_attr_at) begin
          write_attr(ATTR_W'($urandom_range(255)));
          next_attr_at = requests_sent + ATTR_INTERVAL;
        end
      end
    end

    // Wait for the last results, then a short while more in case the block
    // produces anything it should not.
    drain();
    repeat (10) @(negedge clk);

    $display("Run covered %0d requests and %0d checked results, with %0d screen scrolls.",
             requests_sent, checked, scroll_count);
    $display("Attributes 0x00, 0xFF, the reset value and random values; three idling mixes.");
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_addr_unit.sv
hdl/tcw_seq.sv
hdl/text_console_writer.sv
tb/text_console_checker.sv
tb/text_console_writer_tb.sv
